@@ rtl/core/ttep_pkg.sv @@
`default_nettype none
package ttep_pkg;

    localparam int CORDIC_STEPS = 32;
    localparam int SQRT_STEPS   = 32;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int XY_W         = 36;   // cordic x/y, room for pi turn and gain
    localparam int Z_W          = 35;   // Q2.30 angle accumulator with headroom
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int FRONT_LAT    = SQRT_STEPS + 2;

    localparam logic signed [Z_W-1:0] PI_Q30   = 35'sd3373259426;
    localparam logic signed [31:0]    PI_Q29   = 32'sd1686629713;
    localparam logic signed [10:0]    MM_PER_M = 11'sd1000;
    localparam logic [30:0]           THRESH_RESET = 31'd1074;

    typedef struct packed {
        logic signed [31:0] r00;
        logic signed [31:0] r10;
        logic signed [31:0] r11;
        logic signed [31:0] r12;
        logic signed [31:0] r20;
        logic signed [31:0] r21;
        logic signed [31:0] r22;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } ttep_item_t;

    typedef struct packed {
        ttep_item_t  item;
        logic [31:0] sy;
        logic        sing;
    } ttep_task_t;

    // atan(2^-i) in Q2.30, truncated
    function automatic logic signed [Z_W-1:0] atan_entry(input int i);
        logic signed [Z_W-1:0] v;
        v = '0;
        if (i == 0) v = 35'sd843314856;
        else if (i == 1) v = 35'sd497837829;
        else if (i == 2) v = 35'sd263043836;
        else if (i == 3) v = 35'sd133525158;
        else if (i == 4) v = 35'sd67021686;
        else if (i == 5) v = 35'sd33543515;
        else if (i == 6) v = 35'sd16775850;
        else if (i == 7) v = 35'sd8388437;
        else if (i == 8) v = 35'sd4194282;
        else if (i == 9) v = 35'sd2097149;
        else if (i <= 30) v = Z_W'(64'd1 << (30 - i));
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/ttep_front.sv @@
`default_nettype none
module ttep_front
    import ttep_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire ttep_item_t  in_item,
    output logic             out_valid,
    output ttep_item_t       out_item,
    output logic [31:0]      out_sy
);

    // stage 0 squares, stage 1 sum, stages 2.. one root bit each
    logic [FRONT_LAT-1:0] vld_reg;
    ttep_item_t           item_reg [0:FRONT_LAT-1];
    logic [63:0]          sq00_reg;
    logic [63:0]          sq10_reg;
    logic [63:0]          n_reg    [1:FRONT_LAT-1];
    logic [34:0]          rem_reg  [1:FRONT_LAT-1];
    logic [31:0]          root_reg [1:FRONT_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[0] <= in_item;
            sq00_reg    <= 64'($signed(in_item.r00) * $signed(in_item.r00));
            sq10_reg    <= 64'($signed(in_item.r10) * $signed(in_item.r10));
            item_reg[1] <= item_reg[0];
            n_reg[1]    <= sq00_reg + sq10_reg;
            rem_reg[1]  <= '0;
            root_reg[1] <= '0;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [34:0] rem_sh;
        logic [34:0] trial;
        assign rem_sh = {rem_reg[k+1][32:0], n_reg[k+1][63:62]};
        assign trial  = {1'b0, root_reg[k+1], 2'b01};
        always_ff @(posedge aclk) begin
            if (en) begin
                item_reg[k+2] <= item_reg[k+1];
                n_reg[k+2]    <= {n_reg[k+1][61:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg[k+2]  <= rem_sh - trial;
                    root_reg[k+2] <= {root_reg[k+1][30:0], 1'b1};
                end else begin
                    rem_reg[k+2]  <= rem_sh;
                    root_reg[k+2] <= {root_reg[k+1][30:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[FRONT_LAT-1];
    assign out_item  = item_reg[FRONT_LAT-1];
    assign out_sy    = root_reg[FRONT_LAT-1];

endmodule
`default_nettype wire

@@ rtl/core/ttep_fifo.sv @@
`default_nettype none
module ttep_fifo
    import ttep_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire ttep_task_t  wdata,
    output logic             full,
    input  wire logic        pop,
    output ttep_task_t       rdata,
    output logic             empty
);

    ttep_task_t         mem_reg [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] wptr_reg;
    logic [FIFO_AW-1:0] rptr_reg;
    logic [FIFO_AW:0]   cnt_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign rdata = mem_reg[rptr_reg];
    assign full  = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty = (cnt_reg == '0);

endmodule
`default_nettype wire

@@ rtl/core/ttep_cordic.sv @@
`default_nettype none
module ttep_cordic
    import ttep_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   en,
    input  wire logic signed [XY_W-1:0] in_y,
    input  wire logic signed [XY_W-1:0] in_x,
    output logic signed [31:0]          angle
);

    logic signed [XY_W-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_reg [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0]  zero_reg;
    logic signed [Z_W-1:0]  z_rnd;
    logic signed [Z_W-1:0]  z_half;
    logic signed [31:0]     z_sat;

    // left half plane: turn by pi first
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
            if (in_x < 0) begin
                z_reg[0] <= (in_y >= 0) ? PI_Q30 : -PI_Q30;
                x_reg[0] <= -in_x;
                y_reg[0] <= -in_y;
            end else begin
                z_reg[0] <= '0;
                x_reg[0] <= in_x;
                y_reg[0] <= in_y;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
            end
        end
    end

    // round to Q3.29 and clamp to +-pi
    always_comb begin
        z_rnd  = z_reg[CORDIC_STEPS] + Z_W'(1);
        z_half = z_rnd >>> 1;
        if (z_half > Z_W'(PI_Q29))       z_sat = PI_Q29;
        else if (z_half < -Z_W'(PI_Q29)) z_sat = -PI_Q29;
        else                             z_sat = z_half[31:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle <= zero_reg[CORDIC_STEPS] ? '0 : z_sat;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/ttep_back.sv @@
`default_nettype none
module ttep_back
    import ttep_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire ttep_task_t   in_task,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic signed [41:0] pos_x_mm,
    output logic signed [41:0] pos_y_mm,
    output logic signed [41:0] pos_z_mm,
    output logic signed [31:0] angle_x,
    output logic signed [31:0] angle_y,
    output logic signed [31:0] angle_z,
    output logic              singular
);

    logic                    en;
    logic [CORDIC_LAT-1:0]   vld_reg;
    logic signed [41:0]      px_reg [0:CORDIC_LAT-1];
    logic signed [41:0]      py_reg [0:CORDIC_LAT-1];
    logic signed [41:0]      pz_reg [0:CORDIC_LAT-1];
    logic [CORDIC_LAT-1:0]   sing_reg;
    logic signed [XY_W-1:0]  ax_y, ax_x, ay_y, ay_x, az_y, az_x;
    logic signed [31:0]      az_raw;

    assign en       = !vld_reg[CORDIC_LAT-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[CORDIC_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg[0]   <= 42'($signed(in_task.item.trans_x) * MM_PER_M);
            py_reg[0]   <= 42'($signed(in_task.item.trans_y) * MM_PER_M);
            pz_reg[0]   <= 42'($signed(in_task.item.trans_z) * MM_PER_M);
            sing_reg[0] <= in_task.sing;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                px_reg[k]   <= px_reg[k-1];
                py_reg[k]   <= py_reg[k-1];
                pz_reg[k]   <= pz_reg[k-1];
                sing_reg[k] <= sing_reg[k-1];
            end
        end
    end

    // gimbal lock takes rx from the second row
    always_comb begin
        if (in_task.sing) begin
            ax_y = -XY_W'(in_task.item.r12);
            ax_x = XY_W'(in_task.item.r11);
        end else begin
            ax_y = XY_W'(in_task.item.r21);
            ax_x = XY_W'(in_task.item.r22);
        end
        ay_y = -XY_W'(in_task.item.r20);
        ay_x = XY_W'({1'b0, in_task.sy});
        az_y = XY_W'(in_task.item.r10);
        az_x = XY_W'(in_task.item.r00);
    end

    ttep_cordic u_cordic_x (
        .aclk (aclk), .en (en), .in_y (ax_y), .in_x (ax_x), .angle (angle_x)
    );
    ttep_cordic u_cordic_y (
        .aclk (aclk), .en (en), .in_y (ay_y), .in_x (ay_x), .angle (angle_y)
    );
    ttep_cordic u_cordic_z (
        .aclk (aclk), .en (en), .in_y (az_y), .in_x (az_x), .angle (az_raw)
    );

    assign out_valid = vld_reg[CORDIC_LAT-1];
    assign pos_x_mm  = px_reg[CORDIC_LAT-1];
    assign pos_y_mm  = py_reg[CORDIC_LAT-1];
    assign pos_z_mm  = pz_reg[CORDIC_LAT-1];
    assign singular  = sing_reg[CORDIC_LAT-1];
    assign angle_z   = sing_reg[CORDIC_LAT-1] ? '0 : az_raw;

endmodule
`default_nettype wire

@@ rtl/core/transform_to_euler_pose_top.sv @@
`default_nettype none
// transform to zyx euler pose: one homogeneous transform per beat in, one pose per
// beat out; one beat per cycle sustained, passing through the square/root front
// (two multiply/add stages, then one root bit per stage), the four-entry queue
// and the back (three parallel 32-stage cordic pipelines with a turn stage and a
// rounding stage); translation is scaled by 1000 alongside; the front stalls only
// when the queue is full, the back only on m_ready
module transform_to_euler_pose_top
    import ttep_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // threshold write, no handshake
    input  wire logic               cfg_wr_en,
    input  wire logic [30:0]        cfg_wr_data,
    // input beat
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_r00,
    input  wire logic signed [31:0] s_r10,
    input  wire logic signed [31:0] s_r11,
    input  wire logic signed [31:0] s_r12,
    input  wire logic signed [31:0] s_r20,
    input  wire logic signed [31:0] s_r21,
    input  wire logic signed [31:0] s_r22,
    input  wire logic signed [31:0] s_trans_x,
    input  wire logic signed [31:0] s_trans_y,
    input  wire logic signed [31:0] s_trans_z,
    // result beat
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [41:0]      m_pos_x_mm,
    output logic signed [41:0]      m_pos_y_mm,
    output logic signed [41:0]      m_pos_z_mm,
    output logic signed [31:0]      m_angle_x,
    output logic signed [31:0]      m_angle_y,
    output logic signed [31:0]      m_angle_z,
    output logic                    m_singular
);

    logic [30:0] thresh_reg;
    ttep_item_t  s_item;
    logic        f_en;
    logic        f_valid;
    ttep_item_t  f_item;
    logic [31:0] f_sy;
    ttep_task_t  q_wdata;
    ttep_task_t  q_rdata;
    logic        q_full;
    logic        q_empty;
    logic        q_push;
    logic        q_pop;
    logic        b_ready;

    // singular threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            thresh_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        s_item.r00     = s_r00;
        s_item.r10     = s_r10;
        s_item.r11     = s_r11;
        s_item.r12     = s_r12;
        s_item.r20     = s_r20;
        s_item.r21     = s_r21;
        s_item.r22     = s_r22;
        s_item.trans_x = s_trans_x;
        s_item.trans_y = s_trans_y;
        s_item.trans_z = s_trans_z;
    end

    // front advances unless its last beat is blocked by a full queue
    assign f_en    = !(f_valid && q_full);
    assign s_ready = f_en;

    ttep_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (f_en),
        .in_valid  (s_valid),
        .in_item   (s_item),
        .out_valid (f_valid),
        .out_item  (f_item),
        .out_sy    (f_sy)
    );

    // classify at queue entry: gimbal lock when sy below threshold
    always_comb begin
        q_wdata.item = f_item;
        q_wdata.sy   = f_sy;
        q_wdata.sing = f_sy < {1'b0, thresh_reg};
    end

    assign q_push = f_valid && !q_full;
    assign q_pop  = !q_empty && b_ready;

    ttep_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    ttep_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (!q_empty),
        .in_ready  (b_ready),
        .in_task   (q_rdata),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .pos_x_mm  (m_pos_x_mm),
        .pos_y_mm  (m_pos_y_mm),
        .pos_z_mm  (m_pos_z_mm),
        .angle_x   (m_angle_x),
        .angle_y   (m_angle_y),
        .angle_z   (m_angle_z),
        .singular  (m_singular)
    );

    // gimbal lock forces rz to zero
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> m_angle_z == '0)
        else $error("angle_z not zero on singular pose");

    // x and y angles stay within +-pi
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angle_x <= PI_Q29 && m_angle_x >= -PI_Q29 &&
                     m_angle_y <= PI_Q29 && m_angle_y >= -PI_Q29))
        else $error("angle out of range");

    // queue never takes a beat while full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("queue overflow");

endmodule
`default_nettype wire
